// ===== hdl/jls_pkg.sv =====
`timescale 1ns / 1ps

package jls_pkg;

  // Fixed field widths of the item formats.
  localparam int VAL_W  = 32;
  localparam int IDX_W  = 6;
  localparam int PROD_W = 2 * VAL_W;
  // Divider operands: (v - y) * 2^16 needs 49 signed bits, a 48-bit magnitude.
  localparam int NUM_W  = VAL_W + 17;
  localparam int MAG_W  = NUM_W - 1;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  // Input modes.
  localparam logic [1:0] MODE_MAT   = 2'd0;
  localparam logic [1:0] MODE_RHS   = 2'd1;
  localparam logic [1:0] MODE_SOLVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STAT_CONV  = 2'd0;
  localparam logic [1:0] STAT_LIMIT = 2'd1;
  localparam logic [1:0] STAT_ZERO  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_TOL   = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]              mode;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        index;
    logic signed [VAL_W-1:0] solution;
    logic                    last;
    logic [1:0]              status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_MAT,
    CMD_RHS,
    CMD_SOLVE
  } cmd_kind_t;

  // A classified item as it waits in the command queue.
  typedef struct packed {
    cmd_kind_t               kind;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

endpackage

// ===== hdl/jls_ram.sv =====
`timescale 1ns / 1ps

module jls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/jls_front.sv =====
`timescale 1ns / 1ps

module jls_front #(
  parameter int MAX_SIZE = 64
) (
  input  logic              in_valid,
  output logic              in_stall,
  input  jls_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output jls_pkg::cmd_t     q_cmd
);

  logic row_ok;
  logic col_ok;
  logic keep;

  assign row_ok = int'(in_item.row) < MAX_SIZE;
  assign col_ok = int'(in_item.col) < MAX_SIZE;

  // Classify the item; loads outside the store and unknown modes are dropped.
  always_comb begin
    keep        = 1'b0;
    q_cmd.kind  = jls_pkg::CMD_SOLVE;
    q_cmd.row   = in_item.row;
    q_cmd.col   = in_item.col;
    q_cmd.value = in_item.value;
    unique case (in_item.mode)
      jls_pkg::MODE_MAT: begin
        keep       = row_ok && col_ok;
        q_cmd.kind = jls_pkg::CMD_MAT;
      end
      jls_pkg::MODE_RHS: begin
        keep       = row_ok;
        q_cmd.kind = jls_pkg::CMD_RHS;
      end
      jls_pkg::MODE_SOLVE: begin
        keep       = 1'b1;
        q_cmd.kind = jls_pkg::CMD_SOLVE;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // The queue being full holds off every item, dropped ones included.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

// ===== hdl/jls_queue.sv =====
`timescale 1ns / 1ps

module jls_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jls_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output jls_pkg::cmd_t head
);

  localparam int PW = $clog2(DEPTH);

  jls_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [PW:0]   count_r;
  logic          do_pop;

  assign full      = count_r == (PW + 1)'(DEPTH);
  assign not_empty = count_r != '0;
  assign head      = entry_r[rptr_r];
  assign do_pop    = pop && not_empty;

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/jls_div.sv =====
`timescale 1ns / 1ps

module jls_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [jls_pkg::NUM_W-1:0]    num,
  input  logic signed [jls_pkg::VAL_W-1:0]    den,
  output logic                                done,
  output logic signed [jls_pkg::NUM_W-1:0]    quo
);

  localparam int MW = jls_pkg::MAG_W;
  localparam int VW = jls_pkg::VAL_W;

  logic [MW-1:0]          dvd_r;
  logic [VW-1:0]          dsr_r;
  logic [VW-1:0]          rem_r;
  logic [$clog2(MW)-1:0]  cnt_r;
  logic                   busy_r;
  logic                   neg_r;
  logic                   done_r;
  logic [jls_pkg::NUM_W-1:0] num_abs;
  logic [VW-1:0]          den_abs;
  logic [VW:0]            trial;
  logic                   fits;

  assign num_abs = num[jls_pkg::NUM_W-1] ? -num : num;
  assign den_abs = den[VW-1] ? -den : den;
  assign trial   = {rem_r, dvd_r[MW-1]};
  assign fits    = trial >= {1'b0, dsr_r};

  // Restoring division on magnitudes, one quotient bit per cycle; the quotient
  // bits shift in as the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvd_r  <= num_abs[MW-1:0];
        dsr_r  <= den_abs;
        neg_r  <= num[jls_pkg::NUM_W-1] ^ den[VW-1];
      end else if (busy_r) begin
        rem_r <= fits ? VW'(trial - {1'b0, dsr_r}) : trial[VW-1:0];
        dvd_r <= {dvd_r[MW-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ($clog2(MW))'(MW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Truncation toward zero: the sign goes on the magnitude quotient.
  assign quo  = neg_r ? -$signed({1'b0, dvd_r}) : $signed({1'b0, dvd_r});
  assign done = done_r;

endmodule

// ===== hdl/jls_back.sv =====
`timescale 1ns / 1ps

module jls_back #(
  parameter int MAX_SIZE = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  jls_pkg::cmd_t        q_head,
  output logic                 q_pop,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output jls_pkg::out_item_t   out_item
);

  localparam int VW    = jls_pkg::VAL_W;
  localparam int IW    = $clog2(MAX_SIZE);
  localparam int MAW   = $clog2(MAX_SIZE * MAX_SIZE);
  // Width of one product after the Q16 shift.
  localparam int TW    = jls_pkg::PROD_W - 16;
  localparam int ACC_W = TW + IW + 1;
  localparam int SQ_W  = 2 * VW - 16;
  localparam int TOT_W = SQ_W + IW + 1;
  localparam int EST_W = jls_pkg::NUM_W + 1;

  function automatic logic signed [VW-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    if (v[ACC_W-1:VW-1] == '0 || v[ACC_W-1:VW-1] == '1) begin
      return v[VW-1:0];
    end
    return v[ACC_W-1] ? jls_pkg::VAL_MIN : jls_pkg::VAL_MAX;
  endfunction

  function automatic logic signed [VW-1:0] sat_est(input logic signed [EST_W-1:0] v);
    if (v[EST_W-1:VW-1] == '0 || v[EST_W-1:VW-1] == '1) begin
      return v[VW-1:0];
    end
    return v[EST_W-1] ? jls_pkg::VAL_MIN : jls_pkg::VAL_MAX;
  endfunction

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISS,
    S_DDRN,
    S_PISS,
    S_PDRN,
    S_PDEC,
    S_URD,
    S_ULD,
    S_UDIV,
    S_ERD,
    S_ECAP,
    S_EWAIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [6:0]  size_cfg_r;
  logic [31:0] tol_cfg_r;
  logic [15:0] limit_cfg_r;

  // Solve control.
  logic [IW-1:0] nm1_r;
  logic [15:0]   limit_r;
  logic [15:0]   sweep_r;
  logic [IW-1:0] i_r;
  logic [IW-1:0] j_r;
  logic          first_r;
  logic          zero_r;
  logic          d_v_r;
  logic [1:0]    status_r;

  // Product and residual pipeline.
  logic                     s1_v_r;
  logic                     s1_last_r;
  logic [IW-1:0]            s1_row_r;
  logic                     s2_v_r;
  logic                     s2_last_r;
  logic [IW-1:0]            s2_row_r;
  logic signed [jls_pkg::PROD_W-1:0] s2_prod_r;
  logic signed [VW-1:0]     s2_rhs_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     s3_v_r;
  logic [IW-1:0]            s3_row_r;
  logic signed [ACC_W-1:0]  s3_sum_r;
  logic signed [VW-1:0]     s3_rhs_r;
  logic                     s4_v_r;
  logic signed [VW:0]       s4_res_r;
  logic                     s5_v_r;
  logic [SQ_W-1:0]          s5_sq_r;
  logic [TOT_W-1:0]         total_r;

  // Update step.
  logic signed [VW-1:0]     est_old_r;

  // Output register.
  logic                     out_valid_r;
  jls_pkg::out_item_t       out_r;

  // Memory ports.
  logic                 mat_we;
  logic [MAW-1:0]       mat_waddr;
  logic [MAW-1:0]       mat_raddr;
  logic signed [VW-1:0] mat_rd;
  logic                 rhs_we;
  logic [IW-1:0]        rhs_waddr;
  logic signed [VW-1:0] rhs_rd;
  logic                 est_we;
  logic [IW-1:0]        est_raddr;
  logic signed [VW-1:0] est_wdata;
  logic signed [VW-1:0] est_rd;
  logic signed [VW-1:0] est_val;
  logic                 prod_we;
  logic signed [VW-1:0] prod_wdata;
  logic signed [VW-1:0] prod_rd;

  // Divider.
  logic                                div_start;
  logic                                div_done;
  logic signed [jls_pkg::NUM_W-1:0]    div_num;
  logic signed [jls_pkg::NUM_W-1:0]    div_quo;
  logic signed [VW:0]                  upd_diff;

  // Derived values.
  logic signed [ACC_W-1:0] term;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [VW-1:0]    row_y;
  logic [VW:0]             res_abs;
  logic [2*VW-1:0]         res_sq;
  logic [IW:0]             size_eff;
  logic                    idle_pop;

  // Effective problem size, as latched on a start.
  always_comb begin
    if (size_cfg_r == '0) begin
      size_eff = (IW + 1)'(1);
    end else if (int'(size_cfg_r) > MAX_SIZE) begin
      size_eff = (IW + 1)'(MAX_SIZE);
    end else begin
      size_eff = (IW + 1)'(size_cfg_r);
    end
  end

  // Queue commands are taken only between solves; loads write at once.
  assign idle_pop = (state_r == S_IDLE) && q_valid;
  assign q_pop    = idle_pop;

  assign mat_we    = idle_pop && (q_head.kind == jls_pkg::CMD_MAT);
  assign mat_waddr = MAW'(int'(q_head.row) * MAX_SIZE + int'(q_head.col));
  assign rhs_we    = idle_pop && (q_head.kind == jls_pkg::CMD_RHS);
  assign rhs_waddr = IW'(q_head.row);

  // The product walk reads entry (i, j); the other phases read the diagonal.
  assign mat_raddr = (state_r == S_PISS) ? MAW'(int'(i_r) * MAX_SIZE + int'(j_r))
                                         : MAW'(int'(i_r) * MAX_SIZE + int'(i_r));
  assign est_raddr = (state_r == S_PISS) ? j_r : i_r;

  // Before the first sweep ends, the estimate is all zero.
  assign est_val = first_r ? '0 : est_rd;

  // Product row sum and residual datapath; the shifted product stays signed.
  assign term     = ACC_W'($signed(s2_prod_r[jls_pkg::PROD_W-1:16]));
  assign acc_sum  = acc_r + term;
  assign row_y    = sat_acc(s3_sum_r);
  assign res_abs  = s4_res_r[VW] ? -s4_res_r : s4_res_r;
  assign res_sq   = res_abs[VW-1:0] * res_abs[VW-1:0];

  assign prod_we    = s3_v_r;
  assign prod_wdata = row_y;

  // Update: correction (v - y) * 2^16 / a_ii.
  assign upd_diff  = {rhs_rd[VW-1], rhs_rd} - {prod_rd[VW-1], prod_rd};
  assign div_num   = {upd_diff, 16'b0};
  assign div_start = state_r == S_ULD;
  assign est_we    = (state_r == S_UDIV) && div_done;
  assign est_wdata = sat_est(EST_W'(est_old_r) + EST_W'(div_quo));

  jls_ram #(.WIDTH(VW), .DEPTH(MAX_SIZE * MAX_SIZE)) u_mat (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (q_head.value),
    .raddr (mat_raddr),
    .rdata (mat_rd)
  );

  jls_ram #(.WIDTH(VW), .DEPTH(MAX_SIZE)) u_rhs (
    .clk   (clk),
    .we    (rhs_we),
    .waddr (rhs_waddr),
    .wdata (q_head.value),
    .raddr (i_r),
    .rdata (rhs_rd)
  );

  jls_ram #(.WIDTH(VW), .DEPTH(MAX_SIZE)) u_est (
    .clk   (clk),
    .we    (est_we),
    .waddr (i_r),
    .wdata (est_wdata),
    .raddr (est_raddr),
    .rdata (est_rd)
  );

  jls_ram #(.WIDTH(VW), .DEPTH(MAX_SIZE)) u_prod (
    .clk   (clk),
    .we    (prod_we),
    .waddr (s3_row_r),
    .wdata (prod_wdata),
    .raddr (i_r),
    .rdata (prod_rd)
  );

  jls_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (mat_rd),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Sequencer, configuration registers and the registered datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_cfg_r  <= 7'd64;
      tol_cfg_r   <= 32'd66;
      limit_cfg_r <= 16'd1000;
      first_r     <= 1'b1;
      d_v_r       <= 1'b0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      s5_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      sweep_r     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          jls_pkg::CFG_SIZE:  size_cfg_r  <= cfg_data[6:0];
          jls_pkg::CFG_TOL:   tol_cfg_r   <= cfg_data;
          jls_pkg::CFG_LIMIT: limit_cfg_r <= cfg_data[15:0];
          default: ;
        endcase
      end

      // Diagonal check pipeline.
      d_v_r <= state_r == S_DISS;
      if (d_v_r && mat_rd == '0) begin
        zero_r <= 1'b1;
      end

      // Stage 1 to 2: multiply the matrix entry by the estimate.
      s1_v_r    <= state_r == S_PISS;
      s1_last_r <= j_r == nm1_r;
      s1_row_r  <= i_r;
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_last_r;
      s2_row_r  <= s1_row_r;
      s2_prod_r <= mat_rd * est_val;
      s2_rhs_r  <= rhs_rd;

      // Stage 3: row accumulation.
      s3_v_r <= s2_v_r && s2_last_r;
      if (s2_v_r) begin
        acc_r    <= s2_last_r ? '0 : acc_sum;
        s3_sum_r <= acc_sum;
        s3_rhs_r <= s2_rhs_r;
        s3_row_r <= s2_row_r;
      end

      // Stage 4 to 6: residual, its square and the residual total.
      s4_v_r   <= s3_v_r;
      s4_res_r <= {s3_rhs_r[VW-1], s3_rhs_r} - {row_y[VW-1], row_y};
      s5_v_r   <= s4_v_r;
      s5_sq_r  <= res_sq[2*VW-1:16];
      if (s5_v_r) begin
        total_r <= total_r + TOT_W'(s5_sq_r);
      end

      unique case (state_r)
        S_IDLE: begin
          if (q_valid && q_head.kind == jls_pkg::CMD_SOLVE) begin
            nm1_r   <= IW'(size_eff - 1'b1);
            limit_r <= (limit_cfg_r == '0) ? 16'd1 : limit_cfg_r;
            sweep_r <= '0;
            first_r <= 1'b1;
            zero_r  <= 1'b0;
            i_r     <= '0;
            state_r <= S_DISS;
          end
        end
        S_DISS: begin
          if (i_r == nm1_r) begin
            state_r <= S_DDRN;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_DDRN: begin
          if (!d_v_r) begin
            i_r <= '0;
            j_r <= '0;
            if (zero_r) begin
              status_r <= jls_pkg::STAT_ZERO;
              state_r  <= S_ERD;
            end else begin
              acc_r   <= '0;
              total_r <= '0;
              state_r <= S_PISS;
            end
          end
        end
        S_PISS: begin
          if (j_r == nm1_r) begin
            j_r <= '0;
            if (i_r == nm1_r) begin
              state_r <= S_PDRN;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_PDRN: begin
          if (!s1_v_r && !s2_v_r && !s3_v_r && !s4_v_r && !s5_v_r) begin
            state_r <= S_PDEC;
          end
        end
        S_PDEC: begin
          i_r <= '0;
          if (total_r <= TOT_W'(tol_cfg_r)) begin
            status_r <= jls_pkg::STAT_CONV;
            state_r  <= S_ERD;
          end else if (sweep_r >= limit_r) begin
            status_r <= jls_pkg::STAT_LIMIT;
            state_r  <= S_ERD;
          end else begin
            state_r <= S_URD;
          end
        end
        S_URD: begin
          state_r <= S_ULD;
        end
        S_ULD: begin
          est_old_r <= est_val;
          state_r   <= S_UDIV;
        end
        S_UDIV: begin
          if (div_done) begin
            if (i_r == nm1_r) begin
              first_r <= 1'b0;
              sweep_r <= sweep_r + 1'b1;
              i_r     <= '0;
              j_r     <= '0;
              acc_r   <= '0;
              total_r <= '0;
              state_r <= S_PISS;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_URD;
            end
          end
        end
        S_ERD: begin
          state_r <= S_ECAP;
        end
        S_ECAP: begin
          out_r.index    <= jls_pkg::IDX_W'(i_r);
          out_r.solution <= est_val;
          out_r.last     <= i_r == nm1_r;
          out_r.status   <= status_r;
          out_valid_r    <= 1'b1;
          state_r        <= S_EWAIT;
        end
        S_EWAIT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            if (i_r == nm1_r) begin
              state_r <= S_IDLE;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_ERD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== hdl/jacobi_linear_solver.sv =====
`timescale 1ns / 1ps

// Jacobi solver for A*x = v in Q16.16. Matrix entries (mode 0) and right-hand
// elements (mode 1) load at one item per cycle while no solve is running, through
// a four-entry command queue; a start item (mode 2) solves from x = 0 and then
// gives size_eff results, index 0 upward.
// A solve with n unknowns runs a zero-diagonal check, then residual passes, in
// which the matrix memory's single read port yields one product a cycle, and
// update sweeps, one division per unknown on the one-bit-per-cycle divider.
// Items keep queuing during a solve until the queue is full. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module jacobi_linear_solver #(
  parameter int MAX_SIZE = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jls_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output jls_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic          q_full;
  logic          q_push;
  logic          q_pop;
  logic          q_valid;
  jls_pkg::cmd_t q_cmd;
  jls_pkg::cmd_t q_head;

  // Front end: accept and classify items.
  jls_front #(.MAX_SIZE(MAX_SIZE)) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  // Command queue between the two halves.
  jls_queue #(.DEPTH(4)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Back end: stores, solve sequencer and result output.
  jls_back #(.MAX_SIZE(MAX_SIZE)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
